### src/fes_pkg.sv
// ----------------------------------------------------------------------------
// fes_pkg
// Shared types and constants of the fire effect stencil: word formats,
// mode codes and the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package fes_pkg;

    typedef struct packed {
        logic [1:0] mode;
        logic [9:0] col;
        logic [6:0] row;
        logic [7:0] seed_value;
    } t_in;

    typedef struct packed {
        logic [7:0] value;
        logic       status;
    } t_out;

    // operation codes of the mode field
    localparam logic [1:0] MODE_SEED   = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_READ   = 2'd2;

    // decoded kind of the held request
    localparam logic [1:0] KIND_REJECT = 2'd0;
    localparam logic [1:0] KIND_SEED   = 2'd1;
    localparam logic [1:0] KIND_UPDATE = 2'd2;
    localparam logic [1:0] KIND_READ   = 2'd3;

    // memory address select
    localparam logic [2:0] ADDR_TARGET = 3'd0;
    localparam logic [2:0] ADDR_LEFT   = 3'd1;
    localparam logic [2:0] ADDR_BELOW  = 3'd2;
    localparam logic [2:0] ADDR_RIGHT  = 3'd3;
    localparam logic [2:0] ADDR_TWO    = 3'd4;
    localparam logic [2:0] ADDR_CLEAR  = 3'd5;

    // accumulator operation
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;

    // result select
    localparam logic [2:0] RES_HOLD   = 3'd0;
    localparam logic [2:0] RES_REJECT = 3'd1;
    localparam logic [2:0] RES_SEED   = 3'd2;
    localparam logic [2:0] RES_RDATA  = 3'd3;
    localparam logic [2:0] RES_QUOT   = 3'd4;

    // sum * 32 / 129 done as x * 508 >> 16 plus one correction step
    localparam int unsigned SCALE_SHIFT = 5;
    localparam int unsigned DIV_MUL     = 508;
    localparam int unsigned DIV_SHIFT   = 16;
    localparam int unsigned DIVISOR     = 129;

    typedef struct packed {
        logic       in_load;
        logic [2:0] addr_sel;
        logic       ram_we;
        logic       wr_clear;
        logic       clr_inc;
        logic [1:0] acc_op;
        logic       mul_en;
        logic [2:0] res_sel;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic       clr_last;
        logic       out_free;
    } t_stat;

endpackage

### src/fes_ram.sv
// ----------------------------------------------------------------------------
// fes_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module fes_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [DATA_W-1:0]        i_wdata,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### src/fes_ctrl.sv
// ----------------------------------------------------------------------------
// fes_ctrl
// Controller: clearing pass after reset, then one request at a time through
// the memory reads, the divide steps and the write-back that its kind needs.
// ----------------------------------------------------------------------------
module fes_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fes_pkg::t_stat i_stat,
    output fes_pkg::t_cmd  o_cmd
);

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_ISSUE  = 4'd2;
    localparam logic [3:0] ST_RDW    = 4'd3;
    localparam logic [3:0] ST_RD_C   = 4'd4;
    localparam logic [3:0] ST_RD_R   = 4'd5;
    localparam logic [3:0] ST_RD_D   = 4'd6;
    localparam logic [3:0] ST_ACC    = 4'd7;
    localparam logic [3:0] ST_MUL    = 4'd8;
    localparam logic [3:0] ST_CORR   = 4'd9;
    localparam logic [3:0] ST_FINISH = 4'd10;

    logic [3:0]    r_state;
    logic [3:0]    n_state;
    fes_pkg::t_cmd w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state        = r_state;
        w_cmd          = '0;
        w_cmd.addr_sel = fes_pkg::ADDR_TARGET;
        w_cmd.acc_op   = fes_pkg::ACC_HOLD;
        w_cmd.res_sel  = fes_pkg::RES_HOLD;
        unique case (r_state)
            ST_CLEAR: begin
                w_cmd.addr_sel = fes_pkg::ADDR_CLEAR;
                w_cmd.ram_we   = 1'b1;
                w_cmd.wr_clear = 1'b1;
                w_cmd.clr_inc  = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.in_load = 1'b1;
                    n_state       = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                unique case (i_stat.kind)
                    fes_pkg::KIND_SEED: begin
                        w_cmd.res_sel = fes_pkg::RES_SEED;
                        n_state       = ST_FINISH;
                    end
                    fes_pkg::KIND_READ: begin
                        w_cmd.addr_sel = fes_pkg::ADDR_TARGET;
                        n_state        = ST_RDW;
                    end
                    fes_pkg::KIND_UPDATE: begin
                        w_cmd.addr_sel = fes_pkg::ADDR_LEFT;
                        n_state        = ST_RD_C;
                    end
                    default: begin
                        w_cmd.res_sel = fes_pkg::RES_REJECT;
                        n_state       = ST_FINISH;
                    end
                endcase
            end
            ST_RDW: begin
                w_cmd.res_sel = fes_pkg::RES_RDATA;
                n_state       = ST_FINISH;
            end
            ST_RD_C: begin
                w_cmd.addr_sel = fes_pkg::ADDR_BELOW;
                w_cmd.acc_op   = fes_pkg::ACC_LOAD;
                n_state        = ST_RD_R;
            end
            ST_RD_R: begin
                w_cmd.addr_sel = fes_pkg::ADDR_RIGHT;
                w_cmd.acc_op   = fes_pkg::ACC_ADD;
                n_state        = ST_RD_D;
            end
            ST_RD_D: begin
                w_cmd.addr_sel = fes_pkg::ADDR_TWO;
                w_cmd.acc_op   = fes_pkg::ACC_ADD;
                n_state        = ST_ACC;
            end
            ST_ACC: begin
                w_cmd.acc_op = fes_pkg::ACC_ADD;
                n_state      = ST_MUL;
            end
            ST_MUL: begin
                w_cmd.mul_en = 1'b1;
                n_state      = ST_CORR;
            end
            ST_CORR: begin
                w_cmd.res_sel = fes_pkg::RES_QUOT;
                n_state       = ST_FINISH;
            end
            ST_FINISH: begin
                // wait for room in the output register
                if (i_stat.out_free) begin
                    w_cmd.out_load = 1'b1;
                    w_cmd.ram_we   = (i_stat.kind == fes_pkg::KIND_SEED) ||
                                     (i_stat.kind == fes_pkg::KIND_UPDATE);
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    assign o_cmd      = w_cmd;
    assign o_in_stall = (r_state != ST_IDLE);

endmodule

### src/fes_datapath.sv
// ----------------------------------------------------------------------------
// fes_datapath
// Datapath: request register, address generation with wrap, neighbor
// accumulator, constant divide, result and output registers, memory.
// ----------------------------------------------------------------------------
module fes_datapath #(
    parameter int WIDTH  = 640,
    parameter int HEIGHT = 128
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fes_pkg::t_in   i_in_data,
    input  logic           i_out_stall,
    output logic           o_out_valid,
    output fes_pkg::t_out  o_out_data,
    input  fes_pkg::t_cmd  i_cmd,
    output fes_pkg::t_stat o_stat
);

    localparam int CW    = $clog2(WIDTH);
    localparam int RW    = $clog2(HEIGHT);
    localparam int DEPTH = HEIGHT * (1 << CW);
    localparam int AW    = $clog2(DEPTH);

    fes_pkg::t_in  r_item;
    fes_pkg::t_out r_res;
    fes_pkg::t_out r_out;
    logic          r_out_valid;
    logic [9:0]    r_acc;
    logic [14:0]   r_x;
    logic [7:0]    r_q0;
    logic [AW-1:0] r_clr_cnt;

    logic          w_col_ok;
    logic          w_upd_row_ok;
    logic          w_rd_row_ok;
    logic [1:0]    w_kind;
    logic [CW-1:0] w_c;
    logic [CW-1:0] w_cl;
    logic [CW-1:0] w_cr;
    logic [RW-1:0] w_r;
    logic [RW-1:0] w_rb;
    logic [RW-1:0] w_rd;
    logic [RW-1:0] w_rt;
    logic [AW-1:0] w_addr;
    logic [7:0]    w_wdata;
    logic [7:0]    w_rdata;
    logic [14:0]   w_x;
    logic [23:0]   w_prod;
    logic [15:0]   w_rem;
    logic [7:0]    w_quot;

    // request decode
    assign w_col_ok     = {1'b0, r_item.col} < 11'(WIDTH);
    assign w_upd_row_ok = {1'b0, r_item.row} < 8'(HEIGHT - 1);
    assign w_rd_row_ok  = {1'b0, r_item.row} < 8'(HEIGHT);

    always_comb begin
        unique case (r_item.mode)
            fes_pkg::MODE_SEED:
                w_kind = w_col_ok ? fes_pkg::KIND_SEED : fes_pkg::KIND_REJECT;
            fes_pkg::MODE_UPDATE:
                w_kind = (w_col_ok && w_upd_row_ok) ? fes_pkg::KIND_UPDATE
                                                    : fes_pkg::KIND_REJECT;
            fes_pkg::MODE_READ:
                w_kind = (w_col_ok && w_rd_row_ok) ? fes_pkg::KIND_READ
                                                   : fes_pkg::KIND_REJECT;
            default:
                w_kind = fes_pkg::KIND_REJECT;
        endcase
    end

    // neighbor coordinates, columns and rows wrap
    assign w_c  = r_item.col[CW-1:0];
    assign w_r  = r_item.row[RW-1:0];
    assign w_cl = (w_c == '0) ? CW'(WIDTH - 1) : w_c - 1'b1;
    assign w_cr = (w_c == CW'(WIDTH - 1)) ? '0 : w_c + 1'b1;
    assign w_rb = (w_r == RW'(HEIGHT - 1)) ? '0 : w_r + 1'b1;
    assign w_rd = (w_rb == RW'(HEIGHT - 1)) ? '0 : w_rb + 1'b1;
    assign w_rt = (r_item.mode == fes_pkg::MODE_SEED) ? RW'(HEIGHT - 1) : w_r;

    always_comb begin
        unique case (i_cmd.addr_sel)
            fes_pkg::ADDR_LEFT:  w_addr = AW'({w_rb, w_cl});
            fes_pkg::ADDR_BELOW: w_addr = AW'({w_rb, w_c});
            fes_pkg::ADDR_RIGHT: w_addr = AW'({w_rb, w_cr});
            fes_pkg::ADDR_TWO:   w_addr = AW'({w_rd, w_c});
            fes_pkg::ADDR_CLEAR: w_addr = r_clr_cnt;
            default:             w_addr = AW'({w_rt, w_c});
        endcase
    end

    assign w_wdata = i_cmd.wr_clear ? 8'd0 : r_res.value;

    fes_ram #(
        .DATA_W (8),
        .DEPTH  (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ram_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // divide by 129: estimate is exact or one low
    assign w_x    = {r_acc, 5'd0};
    assign w_prod = 24'(w_x) * 24'(fes_pkg::DIV_MUL);
    assign w_rem  = {1'b0, r_x} - (16'(r_q0) * 16'(fes_pkg::DIVISOR));
    assign w_quot = (w_rem >= 16'(fes_pkg::DIVISOR)) ? r_q0 + 8'd1 : r_q0;

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_item <= i_in_data;
        end
        case (i_cmd.acc_op)
            fes_pkg::ACC_LOAD: r_acc <= {2'b00, w_rdata};
            fes_pkg::ACC_ADD:  r_acc <= r_acc + {2'b00, w_rdata};
            default:           r_acc <= r_acc;
        endcase
        if (i_cmd.mul_en) begin
            r_x  <= w_x;
            r_q0 <= w_prod[fes_pkg::DIV_SHIFT +: 8];
        end
        case (i_cmd.res_sel)
            fes_pkg::RES_REJECT: r_res <= '{value: 8'd0, status: 1'b1};
            fes_pkg::RES_SEED:   r_res <= '{value: r_item.seed_value, status: 1'b0};
            fes_pkg::RES_RDATA:  r_res <= '{value: w_rdata, status: 1'b0};
            fes_pkg::RES_QUOT:   r_res <= '{value: w_quot, status: 1'b0};
            default:             r_res <= r_res;
        endcase
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_clr_cnt   <= '0;
        end else begin
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.clr_inc) begin
                r_clr_cnt <= r_clr_cnt + 1'b1;
            end
        end
    end

    assign o_stat.kind     = w_kind;
    assign o_stat.clr_last = (r_clr_cnt == AW'(DEPTH - 1));
    assign o_stat.out_free = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_data      = r_out;

endmodule

### src/fire_effect_stencil.sv
// One word at a time: a seed or rejected word goes straight to the result register,
// a read takes one memory read, and an update reads four neighbors through the
// single memory port and then takes the two-step divide. The next word is taken
// once the result goes into the output register, which waits on a stalled output.
// Reset (synchronous, active low) starts a clearing pass that zeroes all
// HEIGHT * 2**clog2(WIDTH) words (131072 by default); input stall is high meanwhile.
// ----------------------------------------------------------------------------
// fire_effect_stencil
// Intensity store with seed, neighbor update and read operations.
// ----------------------------------------------------------------------------
module fire_effect_stencil #(
    parameter int WIDTH  = 640,
    parameter int HEIGHT = 128
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  fes_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output fes_pkg::t_out o_out_data
);

    fes_pkg::t_cmd  w_cmd;
    fes_pkg::t_stat w_stat;

    fes_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    fes_datapath #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat)
    );

endmodule

### src/fes_checker.sv
// ----------------------------------------------------------------------------
// fes_checker
// Port-level checks of the fire effect stencil, bound to the top level.
// ----------------------------------------------------------------------------
module fes_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_stall,
    input fes_pkg::t_in  i_in_data,
    input logic          o_out_valid,
    input logic          i_out_stall,
    input fes_pkg::t_out o_out_data
);

    // a stalled input word holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_in_data))
        else $error("stalled input word changed");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result word changed");

    // rejected words carry a zero value
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status |-> o_out_data.value == 8'd0)
        else $error("rejected word with nonzero value");

    // one word in flight: input stalls right after an accept
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted back to back");

    // reset empties the output
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_stall)
        else $error("output valid or input open after reset");

endmodule

bind fire_effect_stencil fes_checker u_fes_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);
